// ----- src/fhpta_pkg.sv -----
// Package: shared constants, types and helper functions of the frame and table allocator
`default_nettype none
package fhpta_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int FRAME_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int COL_W      = 5;
    localparam int ROW_W      = FRAME_W - COL_W;
    localparam int COLS       = 1 << COL_W;
    localparam int ROWS       = 1 << ROW_W;
    localparam int ROW_BITS   = 2 * COLS;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FREE_PAGE  = 2'd0;
    localparam kind_t KIND_GET_PAGE   = 2'd1;
    localparam kind_t KIND_ALLOC_TBL  = 2'd2;
    localparam kind_t KIND_FREE_TBL   = 2'd3;

    typedef logic [1:0] hstate_t;
    localparam hstate_t HS_NONE   = 2'd0;
    localparam hstate_t HS_START  = 2'd1;
    localparam hstate_t HS_MIDDLE = 2'd3;

    localparam logic [COUNT_W-1:0] TOTAL_FULL = COUNT_W'(NUM_FRAMES);

    // Lowest set bit of a row summary
    function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
        logic [ROW_W-1:0] idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = ROW_W'(i);
        end
        return idx;
    endfunction

    // Lowest entry of a row that holds a free half
    function automatic logic [COL_W-1:0] first_col(input logic [ROW_BITS-1:0] r);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = COLS - 1; i >= 0; i--)
        begin
            if (r[2*i +: 2] != HS_NONE)
                idx = COL_W'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- src/frame_and_half_page_table_allocator_top.sv -----
// Top level: frame free list and half-page table allocator
//
// An item is accepted at the edge where start is high and busy is low. It then
// passes a read state, which reads the link store and the half-state row store, and
// a modify state, which modifies and writes back; busy is high in those two states
// only. The result appears with done for one cycle, in the cycle after the modify state.
// The next item may start in that same cycle, so items never overlap. After reset
// the half-state store is cleared by a pass over all 32 rows, one row a cycle,
// during which busy is high. The receiver cannot stall.
`default_nettype none
module frame_and_half_page_table_allocator_top
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  kind,
    input  wire logic [fhpta_pkg::FRAME_W-1:0] frame,
    input  wire logic                        half,
    output logic                             done,
    output logic [fhpta_pkg::FRAME_W-1:0]    result_frame,
    output logic                             result_half,
    output logic                             status,
    output logic [fhpta_pkg::COUNT_W-1:0]    frames_free
);
    import fhpta_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_MOD} state_t;

    state_t               state_reg;
    logic [ROW_W-1:0]     clr_reg;
    kind_t                kind_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 half_reg;
    logic [FRAME_W-1:0]   top_reg, top_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [ROWS-1:0]      any_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 scan_reg;
    logic                 done_reg;
    logic [FRAME_W-1:0]   rframe_reg, rframe_next;
    logic                 rhalf_reg, rhalf_next;
    logic                 status_reg, status_next;

    logic [FRAME_W-1:0]   link_mem [NUM_FRAMES];
    logic [ROW_BITS-1:0]  row_mem  [ROWS];
    logic [FRAME_W-1:0]   link_rd_reg;
    logic [ROW_BITS-1:0]  row_rd_reg;

    logic [ROW_W-1:0]     row_addr;
    logic [ROW_BITS-1:0]  row_new;
    logic                 row_we;
    logic                 link_we;
    logic [COL_W-1:0]     col;
    hstate_t              ent;

    // Pick the row to read for the registered item
    always_comb
    begin
        if (kind_reg == KIND_ALLOC_TBL && (|any_reg))
            row_addr = first_row(any_reg);
        else if (kind_reg == KIND_ALLOC_TBL)
            row_addr = top_reg[FRAME_W-1 -: ROW_W];
        else
            row_addr = frame_reg[FRAME_W-1 -: ROW_W];
    end

    // Modify step: work out writes and the result
    always_comb
    begin
        top_next    = top_reg;
        total_next  = total_reg;
        row_new     = row_rd_reg;
        row_we      = 1'b0;
        link_we     = 1'b0;
        rframe_next = '0;
        rhalf_next  = 1'b0;
        status_next = 1'b0;
        col         = frame_reg[COL_W-1:0];
        ent         = HS_NONE;
        case (kind_reg)
            KIND_FREE_PAGE:
            begin
                if (total_reg < TOTAL_FULL)
                begin
                    link_we    = 1'b1;
                    top_next   = frame_reg;
                    total_next = total_reg + 1'b1;
                end
            end
            KIND_GET_PAGE:
            begin
                if (total_reg == '0)
                    status_next = 1'b1;
                else
                begin
                    rframe_next = top_reg;
                    top_next    = link_rd_reg;
                    total_next  = total_reg - 1'b1;
                end
            end
            KIND_ALLOC_TBL:
            begin
                if (scan_reg)
                begin
                    col         = first_col(row_rd_reg);
                    ent         = row_rd_reg[2*col +: 2];
                    rframe_next = {row_reg, col};
                    rhalf_next  = ent[1];
                    row_new[2*col +: 2] = HS_NONE;
                    row_we      = 1'b1;
                end
                else if (total_reg == '0)
                    status_next = 1'b1;
                else
                begin
                    col         = top_reg[COL_W-1:0];
                    rframe_next = top_reg;
                    rhalf_next  = 1'b1;
                    top_next    = link_rd_reg;
                    total_next  = total_reg - 1'b1;
                    row_new[2*col +: 2] = HS_START;
                    row_we      = 1'b1;
                end
            end
            KIND_FREE_TBL:
            begin
                ent    = row_rd_reg[2*col +: 2];
                row_we = 1'b1;
                if (ent != HS_NONE)
                begin
                    row_new[2*col +: 2] = HS_NONE;
                    if (total_reg < TOTAL_FULL)
                    begin
                        link_we    = 1'b1;
                        top_next   = frame_reg;
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                    row_new[2*col +: 2] = half_reg ? HS_MIDDLE : HS_START;
            end
            default:
            begin
                status_next = 1'b0;
            end
        endcase
    end

    // Hold the stores: registered reads, writes in the modify step or the clearing pass
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            link_rd_reg <= link_mem[top_reg];
            row_rd_reg  <= row_mem[row_addr];
        end
        if (state_reg == ST_MOD && link_we)
            link_mem[frame_reg] <= top_reg;
        if (state_reg == ST_MOD && row_we)
            row_mem[row_reg] <= row_new;
        else if (state_reg == ST_CLEAR)
            row_mem[clr_reg] <= '0;
    end

    // Latch the item payload, the chosen row and the result
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            kind_reg  <= kind;
            frame_reg <= frame;
            half_reg  <= half;
        end
        if (state_reg == ST_READ)
        begin
            row_reg  <= row_addr;
            scan_reg <= |any_reg;
        end
        if (state_reg == ST_MOD)
        begin
            rframe_reg <= rframe_next;
            rhalf_reg  <= rhalf_next;
            status_reg <= status_next;
        end
    end

    // Sequence the item and hold list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            top_reg   <= '0;
            total_reg <= '0;
            any_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ROW_W'(ROWS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (start)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_MOD;
                end
                ST_MOD:
                begin
                    top_reg   <= top_next;
                    total_reg <= total_next;
                    if (row_we)
                        any_reg[row_reg] <= |row_new;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_frame = rframe_reg;
    assign result_half  = rhalf_reg;
    assign status       = status_reg;
    assign frames_free  = total_reg;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted item");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_FULL)
        else $error("free count above frame count");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (result_frame == '0 && !result_half && frames_free == '0))
        else $error("failed request with nonzero result");
`endif

endmodule
`default_nettype wire

// ----- test/frame_and_half_page_table_allocator_checker.sv -----
// Checker: predicts allocator results from accepted items and compares them
`default_nettype none
module frame_and_half_page_table_allocator_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic [1:0]                        kind,
    input  wire logic [fhpta_pkg::FRAME_W-1:0]     frame,
    input  wire logic                              half,
    input  wire logic                              done,
    input  wire logic [fhpta_pkg::FRAME_W-1:0]     result_frame,
    input  wire logic                              result_half,
    input  wire logic                              status,
    input  wire logic [fhpta_pkg::COUNT_W-1:0]     frames_free,
    output int                                     fail_count,
    output int                                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fhpta_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] rframe;
        logic               rhalf;
        logic               stat;
        logic [COUNT_W-1:0] nfree;
    } grant_t;

    logic [FRAME_W-1:0] list_head;
    logic [COUNT_W-1:0] list_count;
    logic [FRAME_W-1:0] below [NUM_FRAMES];
    hstate_t            halves [NUM_FRAMES];
    grant_t             grants_due [$];

    // Push a frame onto the free list unless it is full
    function automatic void push_free(input logic [FRAME_W-1:0] f);
        if (list_count < TOTAL_FULL)
        begin
            below[f] = list_head;
            list_head = f;
            list_count++;
        end
    endfunction

    // Work out the grant for one item and advance the shadow state
    function automatic grant_t allocate(input kind_t k, input logic [FRAME_W-1:0] f,
                                        input logic h);
        grant_t g;
        int     low;
        g = '0;
        case (k)
            KIND_FREE_PAGE:
                push_free(f);
            KIND_GET_PAGE:
                if (list_count == 0)
                    g.stat = 1'b1;
                else
                begin
                    g.rframe = list_head;
                    list_head = below[list_head];
                    list_count--;
                end
            KIND_ALLOC_TBL:
            begin
                low = -1;
                for (int i = NUM_FRAMES - 1; i >= 0; i--)
                    if (halves[i] == HS_START || halves[i] == HS_MIDDLE)
                        low = i;
                if (low >= 0)
                begin
                    g.rframe = FRAME_W'(low);
                    g.rhalf = (halves[low] == HS_MIDDLE);
                    halves[low] = HS_NONE;
                end
                else if (list_count == 0)
                    g.stat = 1'b1;
                else
                begin
                    g.rframe = list_head;
                    g.rhalf = 1'b1;
                    halves[list_head] = HS_START;
                    list_head = below[list_head];
                    list_count--;
                end
            end
            default:
                if (halves[f] != HS_NONE)
                begin
                    push_free(f);
                    halves[f] = HS_NONE;
                end
                else
                    halves[f] = h ? HS_MIDDLE : HS_START;
        endcase
        g.nfree = list_count;
        return g;
    endfunction

    assign pending_count = grants_due.size();

    // Predict on accepted items, compare on result strobes
    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            list_head = '0;
            list_count = '0;
            for (int i = 0; i < NUM_FRAMES; i++)
                halves[i] = HS_NONE;
            grants_due.delete();
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("unexpected result: frame %0d", result_frame);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (result_frame !== want.rframe)
                        $error("result_frame: expected %0d, got %0d", want.rframe, result_frame);
                    if (result_half !== want.rhalf)
                        $error("result_half: expected %0d, got %0d", want.rhalf, result_half);
                    if (status !== want.stat)
                        $error("status: expected %0d, got %0d", want.stat, status);
                    if (frames_free !== want.nfree)
                        $error("frames_free: expected %0d, got %0d", want.nfree, frames_free);
                    if ({result_frame, result_half, status, frames_free} !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (start && !busy)
                grants_due.push_back(allocate(kind, frame, half));
        end
    end
endmodule
`default_nettype wire

// ----- test/frame_and_half_page_table_allocator_top_test.sv -----
// Testbench top: stimulus, watchdog and verdict for the frame and table allocator
`default_nettype none
module frame_and_half_page_table_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fhpta_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           kind;
    logic [FRAME_W-1:0]   frame;
    logic                 half;
    logic                 done;
    logic [FRAME_W-1:0]   result_frame;
    logic                 result_half;
    logic                 status;
    logic [COUNT_W-1:0]   frames_free;
    int                   fail_count;
    int                   pending_count;
    int                   idle_pct;
    int                   quiet_cycles;

    frame_and_half_page_table_allocator_top DUT (.*);
    frame_and_half_page_table_allocator_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drive one item and hold it until the block accepts it
    task automatic issue(input kind_t k, input logic [FRAME_W-1:0] f, input logic h);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        frame <= f;
        half <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold the sender until every expected result has come
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Random item, mostly frees of low frames so tables get reused
    task automatic random_item();
        int r;
        logic [FRAME_W-1:0] f;
        r = $urandom_range(99);
        f = FRAME_W'($urandom);
        if (r < 25)
            issue(KIND_FREE_PAGE, (r < 20) ? f & 10'h03F : f, 1'($urandom));
        else if (r < 45)
            issue(KIND_GET_PAGE, f, 1'($urandom));
        else if (r < 70)
            issue(KIND_ALLOC_TBL, f, 1'($urandom));
        else
            issue(KIND_FREE_TBL, (r < 90) ? f & 10'h03F : f, 1'($urandom));
    endtask

    // Count cycles with no item accepted and no result; end the run at the watchdog limit
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_FREE_PAGE;
        frame = '0;
        half = 1'b0;
        idle_pct = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list cases, then extremes of frame and both halves
        issue(KIND_GET_PAGE, '0, 1'b0);
        issue(KIND_ALLOC_TBL, '1, 1'b1);
        issue(KIND_FREE_PAGE, '0, 1'b0);
        issue(KIND_FREE_PAGE, '1, 1'b1);
        issue(KIND_FREE_PAGE, 10'h2AA, 1'b0);
        issue(KIND_GET_PAGE, 10'h155, 1'b1);
        issue(KIND_ALLOC_TBL, '0, 1'b0);
        issue(KIND_ALLOC_TBL, '0, 1'b0);
        issue(KIND_FREE_TBL, '1, 1'b1);
        issue(KIND_FREE_TBL, 10'h155, 1'b0);
        issue(KIND_ALLOC_TBL, '0, 1'b0);
        issue(KIND_FREE_TBL, 10'h155, 1'b1);
        issue(KIND_FREE_TBL, 10'h155, 1'b0);
        issue(KIND_FREE_PAGE, 10'h155, 1'b0);
        issue(KIND_FREE_PAGE, 10'h155, 1'b1);
        issue(KIND_GET_PAGE, '0, 1'b0);
        issue(KIND_GET_PAGE, '0, 1'b0);
        issue(KIND_GET_PAGE, '0, 1'b0);
        issue(KIND_GET_PAGE, '0, 1'b0);
        drain();

        // Fill the list past full so pushes are dropped, idling in phases
        for (int i = 0; i < NUM_FRAMES + 2; i++)
        begin
            idle_pct = (i / 257 == 1) ? 68 : (i / 257 == 3) ? 18 : 0;
            issue(KIND_FREE_PAGE, FRAME_W'(i), 1'b0);
        end
        idle_pct = 0;
        issue(KIND_FREE_TBL, 10'd7, 1'b1);
        issue(KIND_FREE_TBL, 10'd7, 1'b0);
        drain();

        // Random phases with different sender idling
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = (p == 1) ? 68 : (p == 3) ? 18 : 0;
            repeat (6)
                random_item();
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/fhpta_pkg.sv
src/frame_and_half_page_table_allocator_top.sv
test/frame_and_half_page_table_allocator_checker.sv
test/frame_and_half_page_table_allocator_top_test.sv
